### rtl/imusa_pkg.sv
// Shared constants and types for the inertial sample averager.
package imusa_pkg;
   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned NUM_AXES = 6;
   localparam int unsigned QUO_BITS = 48;

   localparam logic [31:0] INTERVAL_RESET = 32'd5000;
   localparam logic [23:0] GYRO_SCALE_RESET = 24'd17855;
   localparam logic [23:0] ACCEL_SCALE_RESET = 24'd80364;
   localparam logic [5:0] NEGATE_RESET = 6'd45;

   localparam logic [1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_GYRO_SCALE = 2'd1;
   localparam logic [1:0] CSR_ACCEL_SCALE = 2'd2;
   localparam logic [1:0] CSR_NEGATE_MASK = 2'd3;

   typedef struct packed {
      logic start;
      logic [COUNT_BITS-1:0] count;
   } lane_ctrl_type;
endpackage

### rtl/imusa_lane.sv
// One averaging lane: scale, floor shift, and bit-serial division by the count.
module imusa_lane
   import imusa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  lane_ctrl_type ctrl,
   input  logic [31:0] sum,
   input  logic [23:0] scale,
   input  logic negate,
   output logic busy,
   output logic [31:0] result
);
   localparam int unsigned STEP_BITS = $clog2(QUO_BITS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_type;

   state_type state_ff, state_in;
   logic [QUO_BITS-1:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [31:0] result_ff, result_in;

   logic signed [56:0] prod_s;
   logic [56:0] mag;
   logic [47:0] shifted;
   logic [COUNT_BITS:0] trial;
   logic [QUO_BITS-1:0] quo_next;

   always_comb begin
      prod_s = 57'(signed'({sum[31], sum})) * 57'(signed'({1'b0, scale}));
      if (negate) begin
         prod_s = -prod_s;
      end
      mag = prod_s[56] ? -prod_s : prod_s;
      // Floor shift on negatives equals a ceiling shift of the magnitude.
      shifted = 48'(mag[56:8]) + 48'((prod_s[56] && (mag[7:0] != 8'd0)) ? 1 : 0);
   end

   always_comb begin
      state_in = state_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      step_in = step_ff;
      result_in = result_ff;
      trial = {rem_ff, quo_ff[QUO_BITS-1]};
      quo_next = {quo_ff[QUO_BITS-2:0], 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               prod_in = shifted;
               neg_in = prod_s[56];
               div_in = ctrl.count;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            quo_in = prod_ff;
            rem_in = '0;
            step_in = STEP_BITS'(QUO_BITS);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = COUNT_BITS'(trial - {1'b0, div_ff});
               quo_in = quo_next | QUO_BITS'(1);
            end else begin
               rem_in = trial[COUNT_BITS-1:0];
               quo_in = quo_next;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               if (neg_ff) begin
                  result_in = (quo_in > 48'h80000000) ? 32'h80000000
                                                      : 32'(-quo_in);
               end else begin
                  result_in = (quo_in > 48'h7FFFFFFF) ? 32'h7FFFFFFF : quo_in[31:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         result_ff <= '0;
      end else begin
         state_ff <= state_in;
         result_ff <= result_in;
      end
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      step_ff <= step_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign result = result_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == ST_IDLE) else $error("lane started while busy");
   a_nonzero_div: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> ctrl.count != '0) else $error("lane started with zero count");
   a_div_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == STEP_BITS'(1)) |=> state_ff == ST_IDLE)
      else $error("division did not finish");
endmodule

### rtl/imu_sample_accumulate_average_top.sv
// Top level of the inertial sample averager: accumulator, lanes, and result merge.
//
// A sample item's result is written to the output register in the cycle after it is accepted.
// An update item runs six lanes in parallel, each a multiply stage followed by a
// 48-step restoring division by the count; the top passes its launch state, then waits
// until no lane is busy and registers the result. One item is in work at a time.
module imu_sample_accumulate_average_top
   import imusa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_type,
   input  logic [31:0] req_sample_time,
   input  logic req_bus_error,
   input  logic signed [15:0] req_accel_x_raw,
   input  logic signed [15:0] req_accel_y_raw,
   input  logic signed [15:0] req_accel_z_raw,
   input  logic signed [15:0] req_gyro_x_raw,
   input  logic signed [15:0] req_gyro_y_raw,
   input  logic signed [15:0] req_gyro_z_raw,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_sample_taken,
   output logic rsp_no_data,
   output logic [15:0] rsp_samples_averaged,
   output logic signed [31:0] rsp_gyro_x_avg,
   output logic signed [31:0] rsp_gyro_y_avg,
   output logic signed [31:0] rsp_gyro_z_avg,
   output logic signed [31:0] rsp_accel_x_avg,
   output logic signed [31:0] rsp_accel_y_avg,
   output logic signed [31:0] rsp_accel_z_avg,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT} state_type;

   state_type state_ff, state_in;
   logic [31:0] interval_ff, interval_in;
   logic [23:0] gscale_ff, gscale_in;
   logic [23:0] ascale_ff, ascale_in;
   logic [5:0] negmask_ff, negmask_in;
   logic [31:0] sums_ff [NUM_AXES], sums_in [NUM_AXES];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0] last_time_ff, last_time_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic taken_ff, taken_in;
   logic nodata_ff, nodata_in;
   logic [15:0] navg_ff, navg_in;
   logic [31:0] avg_ff [NUM_AXES], avg_in [NUM_AXES];

   logic [15:0] raw [NUM_AXES];
   logic [23:0] lane_scale [NUM_AXES];
   logic lane_neg [NUM_AXES];
   logic [NUM_AXES-1:0] lane_busy;
   logic [31:0] lane_res [NUM_AXES];
   lane_ctrl_type ctrl;
   logic req_fire, gate_pass;
   logic [COUNT_BITS-1:0] count_inc;

   // Axis order: accel x, y, z then gyro x, y, z.
   assign raw[0] = req_accel_x_raw;
   assign raw[1] = req_accel_y_raw;
   assign raw[2] = req_accel_z_raw;
   assign raw[3] = req_gyro_x_raw;
   assign raw[4] = req_gyro_y_raw;
   assign raw[5] = req_gyro_z_raw;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign req_fire = req_valid && req_ready;
   assign gate_pass = (req_sample_time - last_time_ff) >= interval_ff;
   assign count_inc = count_ff + 1'b1;
   assign ctrl.start = (state_ff == ST_LAUNCH);
   assign ctrl.count = count_ff;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      assign lane_scale[i] = (i < 3) ? ascale_ff : gscale_ff;
      assign lane_neg[i] = negmask_ff[(i + 3) % NUM_AXES];
      imusa_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sum    (sums_ff[i]),
         .scale  (lane_scale[i]),
         .negate (lane_neg[i]),
         .busy   (lane_busy[i]),
         .result (lane_res[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      interval_in = interval_ff;
      gscale_in = gscale_ff;
      ascale_in = ascale_ff;
      negmask_in = negmask_ff;
      sums_in = sums_ff;
      count_in = count_ff;
      last_time_in = last_time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      taken_in = taken_ff;
      nodata_in = nodata_ff;
      navg_in = navg_ff;
      avg_in = avg_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_INTERVAL: interval_in = csr_data;
            CSR_GYRO_SCALE: gscale_in = csr_data[23:0];
            CSR_ACCEL_SCALE: ascale_in = csr_data[23:0];
            CSR_NEGATE_MASK: negmask_in = csr_data[5:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               taken_in = 1'b0;
               nodata_in = 1'b0;
               navg_in = '0;
               for (int i = 0; i < NUM_AXES; i++) begin
                  avg_in[i] = '0;
               end
               if (!req_type) begin
                  rsp_valid_in = 1'b1;
                  if (gate_pass) begin
                     last_time_in = req_sample_time;
                     if (!req_bus_error) begin
                        taken_in = 1'b1;
                        count_in = count_inc;
                        for (int i = 0; i < NUM_AXES; i++) begin
                           sums_in[i] = (count_inc == '0) ? '0
                              : sums_ff[i] + {{16{raw[i][15]}}, raw[i]};
                        end
                     end
                  end
               end else if (count_ff == '0) begin
                  nodata_in = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (lane_busy == '0) begin
               navg_in = 16'(count_ff);
               avg_in[0] = lane_res[3];
               avg_in[1] = lane_res[4];
               avg_in[2] = lane_res[5];
               avg_in[3] = lane_res[0];
               avg_in[4] = lane_res[1];
               avg_in[5] = lane_res[2];
               count_in = '0;
               for (int i = 0; i < NUM_AXES; i++) begin
                  sums_in[i] = '0;
               end
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         interval_ff <= INTERVAL_RESET;
         gscale_ff <= GYRO_SCALE_RESET;
         ascale_ff <= ACCEL_SCALE_RESET;
         negmask_ff <= NEGATE_RESET;
         for (int i = 0; i < NUM_AXES; i++) begin
            sums_ff[i] <= '0;
         end
         count_ff <= '0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         interval_ff <= interval_in;
         gscale_ff <= gscale_in;
         ascale_ff <= ascale_in;
         negmask_ff <= negmask_in;
         sums_ff <= sums_in;
         count_ff <= count_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      taken_ff <= taken_in;
      nodata_ff <= nodata_in;
      navg_ff <= navg_in;
      avg_ff <= avg_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_taken = taken_ff;
   assign rsp_no_data = nodata_ff;
   assign rsp_samples_averaged = navg_ff;
   assign rsp_gyro_x_avg = avg_ff[0];
   assign rsp_gyro_y_avg = avg_ff[1];
   assign rsp_gyro_z_avg = avg_ff[2];
   assign rsp_accel_x_avg = avg_ff[3];
   assign rsp_accel_y_avg = avg_ff[4];
   assign rsp_accel_z_avg = avg_ff[5];

   a_launch_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LAUNCH |-> count_ff != '0) else $error("launch with zero count");
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(taken_ff && nodata_ff)) else $error("conflicting flags");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff) else $error("result during update");
endmodule
